@@ design/vne_pkg.sv @@
// shared types and constants of the vertex near edge test
// field widths, stream packing widths, parameter defaults and the stage tag
// no dependencies
`default_nettype none

package vne_pkg;

  // fixed field widths
  localparam int ID_W    = 20;
  localparam int COORD_W = 32;
  localparam int TOL_W   = 31;
  localparam int POS_W   = 16;

  // packed stream widths
  localparam int IN_W  = 6 * COORD_W + 4 * ID_W;
  localparam int OUT_W = 2 * ID_W + POS_W;

  // parameter defaults
  localparam int DEF_ID_BITS       = 20;
  localparam int DEF_COORD_BITS    = 32;
  localparam int DEF_FRACTION_BITS = 16;

  // control tag that travels with every stage
  typedef struct packed {
    logic            valid;
    logic            hit;
    logic [ID_W-1:0] edge_idx;
    logic [ID_W-1:0] point_id;
  } vne_tag_t;

endpackage

`default_nettype wire

@@ design/vertex_near_edge_test.sv @@
// top level of the vertex near edge test: point to segment proximity pipeline
// eight arithmetic stages, a chain of vne_div_step, output register and skid
// depends on vne_pkg and vne_div_step
//
//  channel | direction | handshake                 | payload
//  in_     | slave     | in_tvalid / in_tready     | in_tdata: vertex, edge endpoints, ids
//  out_    | master    | out_tvalid / out_tready   | out_tdata: ids, position; out_tuser: hit
//  cfg_    | slave     | cfg_valid / cfg_ready     | cfg_data: tolerance
//
// one request accepted per cycle when nothing stalls
// a request passes through the 8 arithmetic stages, one stage per quotient
// bit, and then the output register
// in_tready drops only while the skid register holds a result; the whole pipe
// then holds, bubbles included
// reset clears valid bits and the tolerance; no clearing pass
`default_nettype none

module vertex_near_edge_test #(
  parameter int ID_BITS       = vne_pkg::DEF_ID_BITS,
  parameter int COORD_BITS    = vne_pkg::DEF_COORD_BITS,
  parameter int FRACTION_BITS = vne_pkg::DEF_FRACTION_BITS
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  // point_x, point_y, point_id, start_x, start_y, start_id, end_x, end_y,
  // end_id, edge_index
  input  wire logic [vne_pkg::IN_W-1:0]  in_tdata,
  input  wire logic                      in_tvalid,
  output logic                           in_tready,
  // hit_edge, hit_point, position
  output logic [vne_pkg::OUT_W-1:0]      out_tdata,
  // hit
  output logic                           out_tuser,
  output logic                           out_tvalid,
  input  wire logic                      out_tready,
  input  wire logic [vne_pkg::TOL_W-1:0] cfg_data,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready
);
  import vne_pkg::*;

  // derived widths
  localparam int C      = COORD_BITS;
  localparam int D      = C + 1;
  localparam int HW     = D;
  localparam int PW     = 2 * D;
  localparam int SW     = 2 * D + 1;
  localparam int RW     = 2 * HW;
  localparam int TH     = TOL_W;
  localparam int TSQ_W  = 2 * TOL_W;
  localparam int RP_W   = TH + HW;
  localparam int MID_W  = TH + HW + ((TH > HW) ? TH : HW) + 1;
  localparam int CMP_W  = (4 * HW > 2 * TH + 2 * HW) ? 4 * HW : 2 * TH + 2 * HW;
  localparam int QW     = FRACTION_BITS;
  localparam int ID_KEEP = (ID_BITS < ID_W) ? ID_BITS : ID_W;
  localparam logic [ID_W-1:0] ID_MASK = {ID_W{1'b1}} >> (ID_W - ID_KEEP);

  // input field offsets
  localparam int PX_LO   = 0;
  localparam int PY_LO   = PX_LO + COORD_W;
  localparam int PID_LO  = PY_LO + COORD_W;
  localparam int SX_LO   = PID_LO + ID_W;
  localparam int SY_LO   = SX_LO + COORD_W;
  localparam int SID_LO  = SY_LO + COORD_W;
  localparam int EX_LO   = SID_LO + ID_W;
  localparam int EY_LO   = EX_LO + COORD_W;
  localparam int EID_LO  = EY_LO + COORD_W;
  localparam int EDGE_LO = EID_LO + ID_W;

  // output field offsets
  localparam int HE_LO  = 0;
  localparam int HP_LO  = HE_LO + ID_W;
  localparam int POS_LO = HP_LO + ID_W;

  logic en;

  // tolerance register and its square
  logic [TOL_W-1:0] tol_r;
  logic [TSQ_W-1:0] tol_sq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r    <= '0;
      tol_sq_r <= '0;
    end else begin
      if (cfg_valid) begin
        tol_r <= cfg_data;
      end
      tol_sq_r <= tol_r * tol_r;
    end
  end

  assign cfg_ready = 1'b1;

  // stage 1: unpack, edge vector, vertex offset, endpoint check
  logic signed [C-1:0] px, py, sx, sy, ex, ey;
  logic [ID_W-1:0]     pid, sid, eid, edx;
  vne_tag_t            tag1_nxt, tag1_r;
  logic signed [D-1:0] abx_nxt, aby_nxt, apx_nxt, apy_nxt;
  logic signed [D-1:0] abx_r, aby_r, apx_r, apy_r;

  always_comb begin
    px  = in_tdata[PX_LO +: C];
    py  = in_tdata[PY_LO +: C];
    sx  = in_tdata[SX_LO +: C];
    sy  = in_tdata[SY_LO +: C];
    ex  = in_tdata[EX_LO +: C];
    ey  = in_tdata[EY_LO +: C];
    pid = in_tdata[PID_LO +: ID_W] & ID_MASK;
    sid = in_tdata[SID_LO +: ID_W] & ID_MASK;
    eid = in_tdata[EID_LO +: ID_W] & ID_MASK;
    edx = in_tdata[EDGE_LO +: ID_W] & ID_MASK;
    abx_nxt = {ex[C-1], ex} - {sx[C-1], sx};
    aby_nxt = {ey[C-1], ey} - {sy[C-1], sy};
    apx_nxt = {px[C-1], px} - {sx[C-1], sx};
    apy_nxt = {py[C-1], py} - {sy[C-1], sy};
    tag1_nxt.valid    = in_tvalid;
    tag1_nxt.hit      = (pid != sid) && (pid != eid);
    tag1_nxt.edge_idx = edx;
    tag1_nxt.point_id = pid;
  end

  // stage 2: six signed products
  vne_tag_t             tag2_r;
  logic signed [PW-1:0] len_a_r, len_b_r, dot_a_r, dot_b_r, cr_a_r, cr_b_r;

  // stage 3: len2, dot, cross
  vne_tag_t             tag3_r;
  logic signed [SW-1:0] len2_nxt, dot_nxt, cross_nxt;
  logic signed [SW-1:0] len2_r, dot_r, cross_r;

  always_comb begin
    len2_nxt  = {len_a_r[PW-1], len_a_r} + {len_b_r[PW-1], len_b_r};
    dot_nxt   = {dot_a_r[PW-1], dot_a_r} + {dot_b_r[PW-1], dot_b_r};
    cross_nxt = {cr_a_r[PW-1], cr_a_r} - {cr_b_r[PW-1], cr_b_r};
  end

  // stage 4: range checks and cross magnitude
  vne_tag_t             tag4_nxt, tag4_r;
  logic signed [SW-1:0] dl_diff, cross_neg;
  logic [RW-1:0]        cabs_nxt, cabs_r, len_u4_r, dot_u4_r;

  always_comb begin
    dl_diff   = dot_r - len2_r;
    cross_neg = -cross_r;
    cabs_nxt  = cross_r[SW-1] ? cross_neg[RW-1:0] : cross_r[RW-1:0];
    tag4_nxt     = tag3_r;
    tag4_nxt.hit = tag3_r.hit && (len2_r != '0) && !dot_r[SW-1] && (dot_r != '0) &&
                   dl_diff[SW-1];
  end

  // stage 5: partial products of cross squared and tol squared times len2
  vne_tag_t       tag5_r;
  logic [HW-1:0]  c1, c0, l1, l0;
  logic [TH-1:0]  t1, t0;
  logic [RW-1:0]  sq_hh_nxt, sq_hl_nxt, sq_ll_nxt, sq_hh_r, sq_hl_r, sq_ll_r;
  logic [RP_W-1:0] r00_nxt, r01_nxt, r10_nxt, r11_nxt, r00_r, r01_r, r10_r, r11_r;
  logic [RW-1:0]  len_u5_r, dot_u5_r;

  always_comb begin
    c1 = cabs_r[RW-1:HW];
    c0 = cabs_r[HW-1:0];
    l1 = len_u4_r[RW-1:HW];
    l0 = len_u4_r[HW-1:0];
    t1 = tol_sq_r[TSQ_W-1:TH];
    t0 = tol_sq_r[TH-1:0];
    sq_hh_nxt = c1 * c1;
    sq_hl_nxt = c1 * c0;
    sq_ll_nxt = c0 * c0;
    r00_nxt   = t0 * l0;
    r01_nxt   = t0 * l1;
    r10_nxt   = t1 * l0;
    r11_nxt   = t1 * l1;
  end

  // stage 6: cross squared, middle sum of the tolerance product
  vne_tag_t         tag6_r;
  logic [CMP_W-1:0] lhs_nxt, lhs6_r;
  logic [MID_W-1:0] rmid_nxt, rmid_r;
  logic [RP_W-1:0]  r00_6_r, r11_6_r;
  logic [RW-1:0]    len_u6_r, dot_u6_r;

  always_comb begin
    lhs_nxt  = CMP_W'({sq_hh_r, sq_ll_r}) + (CMP_W'(sq_hl_r) << (HW + 1));
    rmid_nxt = (MID_W'(r10_r) << TH) + (MID_W'(r01_r) << HW);
  end

  // stage 7: tolerance product
  vne_tag_t         tag7_r;
  logic [CMP_W-1:0] rhs_nxt, rhs_r, lhs7_r;
  logic [RW-1:0]    len_u7_r, dot_u7_r;

  always_comb begin
    rhs_nxt = CMP_W'({r11_6_r, r00_6_r}) + CMP_W'(rmid_r);
  end

  // stage 8: final compare
  vne_tag_t      tag8_nxt, tag8_r;
  logic [RW-1:0] len_u8_r, dot_u8_r;

  always_comb begin
    tag8_nxt     = tag7_r;
    tag8_nxt.hit = tag7_r.hit && (rhs_r >= lhs7_r);
  end

  // arithmetic stage tags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag1_r <= '0;
      tag2_r <= '0;
      tag3_r <= '0;
      tag4_r <= '0;
      tag5_r <= '0;
      tag6_r <= '0;
      tag7_r <= '0;
      tag8_r <= '0;
    end else if (en) begin
      tag1_r <= tag1_nxt;
      tag2_r <= tag1_r;
      tag3_r <= tag2_r;
      tag4_r <= tag4_nxt;
      tag5_r <= tag4_r;
      tag6_r <= tag5_r;
      tag7_r <= tag6_r;
      tag8_r <= tag8_nxt;
    end
  end

  // arithmetic stage payload
  always_ff @(posedge clk) begin
    if (en) begin
      abx_r    <= abx_nxt;
      aby_r    <= aby_nxt;
      apx_r    <= apx_nxt;
      apy_r    <= apy_nxt;
      len_a_r  <= abx_r * abx_r;
      len_b_r  <= aby_r * aby_r;
      dot_a_r  <= apx_r * abx_r;
      dot_b_r  <= apy_r * aby_r;
      cr_a_r   <= apx_r * aby_r;
      cr_b_r   <= apy_r * abx_r;
      len2_r   <= len2_nxt;
      dot_r    <= dot_nxt;
      cross_r  <= cross_nxt;
      cabs_r   <= cabs_nxt;
      len_u4_r <= len2_r[RW-1:0];
      dot_u4_r <= dot_r[RW-1:0];
      sq_hh_r  <= sq_hh_nxt;
      sq_hl_r  <= sq_hl_nxt;
      sq_ll_r  <= sq_ll_nxt;
      r00_r    <= r00_nxt;
      r01_r    <= r01_nxt;
      r10_r    <= r10_nxt;
      r11_r    <= r11_nxt;
      len_u5_r <= len_u4_r;
      dot_u5_r <= dot_u4_r;
      lhs6_r   <= lhs_nxt;
      rmid_r   <= rmid_nxt;
      r00_6_r  <= r00_r;
      r11_6_r  <= r11_r;
      len_u6_r <= len_u5_r;
      dot_u6_r <= dot_u5_r;
      rhs_r    <= rhs_nxt;
      lhs7_r   <= lhs6_r;
      len_u7_r <= len_u6_r;
      dot_u7_r <= dot_u6_r;
      len_u8_r <= len_u7_r;
      dot_u8_r <= dot_u7_r;
    end
  end

  // division chain, one quotient bit per stage
  vne_tag_t      dtag [QW+1];
  logic [RW-1:0] drem [QW+1];
  logic [RW-1:0] dlen [QW+1];
  logic [QW-1:0] dquo [QW+1];

  assign dtag[0] = tag8_r;
  assign drem[0] = dot_u8_r;
  assign dlen[0] = len_u8_r;
  assign dquo[0] = '0;

  for (genvar k = 0; k < QW; k++) begin : g_div
    vne_div_step #(
      .RW (RW),
      .QW (QW)
    ) u_step (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .tag_i (dtag[k]),
      .rem_i (drem[k]),
      .len_i (dlen[k]),
      .quo_i (dquo[k]),
      .tag_o (dtag[k+1]),
      .rem_o (drem[k+1]),
      .len_o (dlen[k+1]),
      .quo_o (dquo[k+1])
    );
  end

  // result of the last stage
  vne_tag_t         last_tag;
  logic [OUT_W-1:0] last_data;

  always_comb begin
    last_tag  = dtag[QW];
    last_data = '0;
    last_data[HE_LO +: ID_W]  = last_tag.edge_idx;
    last_data[HP_LO +: ID_W]  = last_tag.point_id;
    last_data[POS_LO +: POS_W] = last_tag.hit ? POS_W'(dquo[QW]) : '0;
  end

  // output register and skid register
  logic             out_valid_r, out_valid_nxt, skid_valid_r, skid_valid_nxt;
  logic             out_hit_r, out_hit_nxt, skid_hit_r, skid_hit_nxt;
  logic [OUT_W-1:0] out_data_r, out_data_nxt, skid_data_r, skid_data_nxt;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_hit_nxt    = out_hit_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_hit_nxt   = skid_hit_r;
    skid_data_nxt  = skid_data_r;
    if (skid_valid_r) begin
      if (out_tready) begin
        out_hit_nxt    = skid_hit_r;
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (!out_valid_r || out_tready) begin
      out_valid_nxt = last_tag.valid;
      out_hit_nxt   = last_tag.hit;
      out_data_nxt  = last_data;
    end else if (last_tag.valid) begin
      skid_valid_nxt = 1'b1;
      skid_hit_nxt   = last_tag.hit;
      skid_data_nxt  = last_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_hit_r   <= out_hit_nxt;
    out_data_r  <= out_data_nxt;
    skid_hit_r  <= skid_hit_nxt;
    skid_data_r <= skid_data_nxt;
  end

  // pipe advances while the skid register is free
  assign en         = !skid_valid_r;
  assign in_tready  = en;
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_hit_r;
  assign out_tdata  = out_data_r;

  // skid only fills behind a waiting output
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid holds a result while the output register is empty");

  // a held skid result is not overwritten
  a_skid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r && !out_tready |=> skid_valid_r && $stable(skid_data_r) &&
                                    $stable(skid_hit_r))
    else $error("skid result changed while stalled");

  // a miss carries a zero position
  a_miss_zero_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[POS_LO +: POS_W] == '0)
    else $error("position nonzero on a miss");

  // a stalled pipe keeps its last stage
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !en && last_tag.valid |=> last_tag.valid && $stable(last_data))
    else $error("last stage changed during a stall");

endmodule

`default_nettype wire

@@ design/vne_div_step.sv @@
// one restoring division step of the position pipeline
// produces one quotient bit per stage; depends on vne_pkg
`default_nettype none

module vne_div_step #(
  parameter int RW = 66,
  parameter int QW = 16
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                en,
  input  wire vne_pkg::vne_tag_t   tag_i,
  input  wire logic [RW-1:0]       rem_i,
  input  wire logic [RW-1:0]       len_i,
  input  wire logic [QW-1:0]       quo_i,
  output vne_pkg::vne_tag_t        tag_o,
  output logic [RW-1:0]            rem_o,
  output logic [RW-1:0]            len_o,
  output logic [QW-1:0]            quo_o
);
  import vne_pkg::*;

  vne_tag_t      tag_r;
  logic [RW-1:0] rem_r, rem_nxt;
  logic [RW-1:0] len_r;
  logic [QW-1:0] quo_r, quo_nxt;
  logic [RW-1:0] shifted;
  logic [RW:0]   diff;

  // trial subtract of the doubled remainder
  always_comb begin
    shifted = {rem_i[RW-2:0], 1'b0};
    diff    = {1'b0, shifted} - {1'b0, len_i};
    if (!diff[RW]) begin
      rem_nxt = diff[RW-1:0];
      quo_nxt = {quo_i[QW-2:0], 1'b1};
    end else begin
      rem_nxt = shifted;
      quo_nxt = {quo_i[QW-2:0], 1'b0};
    end
  end

  // stage tag with valid bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r <= '0;
    end else if (en) begin
      tag_r <= tag_i;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= rem_nxt;
      len_r <= len_i;
      quo_r <= quo_nxt;
    end
  end

  assign tag_o = tag_r;
  assign rem_o = rem_r;
  assign len_o = len_r;
  assign quo_o = quo_r;

endmodule

`default_nettype wire
